[hdl/rtpd_pkg.sv]
// ----------------------------------------------------------------------------
// rtpd_pkg
// Shared constants and types of the RTP H.264 depacketizer.
// ----------------------------------------------------------------------------
package rtpd_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_MAX         = POS_W'(MAX_PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PAYLOAD_HDR = POS_W'(12);
  localparam logic [POS_W-1:0] POS_FU_HDR      = POS_W'(13);
  localparam logic [POS_W-1:0] POS_PAYLOAD     = POS_W'(14);

  localparam logic [4:0] FUA_TYPE  = 5'd28;
  localparam logic [7:0] TYPE_MASK = 8'h1f;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_ONE   = 3'd3;
  localparam logic [2:0] PH_LAST  = 3'd4;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[hdl/rtpd_front.sv]
// ----------------------------------------------------------------------------
// rtpd_front
// Tracks the byte position within each packet and turns every input beat
// into at most one command for the output sequencer.
// ----------------------------------------------------------------------------
module rtpd_front import rtpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] pkt_byte,
  input  logic       last_of_packet,
  output logic       push,
  output cmd_t       cmd
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             frag_r, frag_nxt;
  logic [2:0]       fnri_r, fnri_nxt;
  logic             emit;

  always_comb begin
    emit      = 1'b0;
    cmd.start = 1'b0;
    cmd.data  = pkt_byte;
    frag_nxt  = frag_r;
    fnri_nxt  = fnri_r;
    if (pos_r == POS_PAYLOAD_HDR) begin
      if (pkt_byte[4:0] == FUA_TYPE) begin
        frag_nxt = 1'b1;
        fnri_nxt = pkt_byte[7:5];
      end else begin
        frag_nxt  = 1'b0;
        emit      = 1'b1;
        cmd.start = 1'b1;
      end
    end else if (pos_r == POS_FU_HDR) begin
      if (frag_r) begin
        if (pkt_byte[7] && !pkt_byte[6]) begin
          emit      = 1'b1;
          cmd.start = 1'b1;
          cmd.data  = {fnri_r, 5'b0} | (pkt_byte & TYPE_MASK);
        end
      end else begin
        emit = 1'b1;
      end
    end else if (pos_r >= POS_PAYLOAD) begin
      emit = 1'b1;
    end

    if (last_of_packet) begin
      pos_nxt  = '0;
      frag_nxt = 1'b0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign push = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      frag_r <= 1'b0;
      fnri_r <= '0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      frag_r <= frag_nxt;
      fnri_r <= fnri_nxt;
    end
  end

endmodule

[hdl/rtpd_queue.sv]
// ----------------------------------------------------------------------------
// rtpd_queue
// Small command queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module rtpd_queue import rtpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      wr_cmd,
  input  logic      pop,
  output cmd_t      rd_cmd,
  output q_status_t status
);

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign rd_cmd       = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

endmodule

[hdl/rtpd_back.sv]
// ----------------------------------------------------------------------------
// rtpd_back
// Expands queued commands into output beats: a start command gives a
// four-byte start code and its header byte, a plain command one byte.
// ----------------------------------------------------------------------------
module rtpd_back import rtpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_status_t status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      out_nal_begin,
  output logic      out_last_of_run
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       begin_r, last_r;
  logic [2:0] ph_r, ph_nxt;
  logic       load;
  logic [7:0] byte_nxt;
  logic       begin_nxt, last_nxt;

  assign load = !status.empty && (!valid_r || !out_stall);

  always_comb begin
    byte_nxt  = head.data;
    begin_nxt = 1'b0;
    last_nxt  = 1'b1;
    ph_nxt    = PH_FIRST;
    if (head.start && ph_r != PH_LAST) begin
      byte_nxt  = (ph_r == PH_ONE) ? 8'h01 : 8'h00;
      begin_nxt = (ph_r == PH_FIRST);
      last_nxt  = 1'b0;
      ph_nxt    = ph_r + 3'd1;
    end
  end

  assign pop = load && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ph_r    <= PH_FIRST;
    end else if (load) begin
      valid_r <= 1'b1;
      ph_r    <= ph_nxt;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      begin_r <= begin_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_nal_begin   = begin_r;
  assign out_last_of_run = last_r;

endmodule

[hdl/rtp_h264_depacketizer.sv]
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer
// RTP to H.264 Annex B depacketizer for single NAL unit and FU-A packets.
// ----------------------------------------------------------------------------
// The input channel takes one packet byte per beat, with in_last_of_packet
// set on the final byte of each packet. The result channel gives one byte
// of the Annex B stream per beat; out_nal_begin marks the first byte of a
// start code and out_last_of_run the final beat caused by one input byte.
// An input byte that yields output goes through the command queue, then the
// output register. Payload bytes flow at one beat per cycle while the
// receiver takes them; a NAL header costs five output beats (start code
// and header byte), so the input takes one byte per cycle except while
// the four-entry command queue is full, which happens only behind such a
// five-beat burst or a stalled receiver. Header bytes of the RTP packet
// produce no beat. Reset clears the byte position, the fragment state,
// the queue and the output valid flag. When the receiver stalls, the
// current beat holds and the queue fills; in_stall rises once it is full.
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer import rtpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pkt_byte,
  input  logic       in_last_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_nal_begin,
  output logic       out_last_of_run
);

  logic      acc, push, pop;
  cmd_t      wr_cmd, head;
  q_status_t status;

  assign in_stall = status.full;
  assign acc      = in_valid && !status.full;

  rtpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .pkt_byte       (in_pkt_byte),
    .last_of_packet (in_last_of_packet),
    .push           (push),
    .cmd            (wr_cmd)
  );

  rtpd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (head),
    .status (status)
  );

  rtpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .status          (status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_nal_begin   (out_nal_begin),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[hdl/rtpd_checker.sv]
// ----------------------------------------------------------------------------
// rtpd_checker
// Port-level checks of the depacketizer, bound to the top level.
// ----------------------------------------------------------------------------
module rtpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_nal_begin,
  input logic       out_last_of_run
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_nal_begin) && $stable(out_last_of_run))
    else $error("stalled output beat changed");

  a_begin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nal_begin |-> out_byte == 8'h00 && !out_last_of_run)
    else $error("start code beat malformed");

  a_begin_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_nal_begin |=>
      !out_valid || (!out_nal_begin && out_byte == 8'h00 && !out_last_of_run))
    else $error("start code not continued");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind rtp_h264_depacketizer rtpd_checker u_rtpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_nal_begin   (out_nal_begin),
  .out_last_of_run (out_last_of_run)
);

[verif/rtpd_annexb_checker.sv]
// ----------------------------------------------------------------------------
// rtpd_annexb_checker
// Watches both channels of the depacketizer, predicts the Annex B beats that
// each accepted packet byte causes and compares every output beat, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rtpd_annexb_checker import rtpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_pkt_byte,
  input  logic       in_last_of_packet,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_nal_begin,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       nal_begin;
    logic       run_end;
  } annexb_beat_t;

  annexb_beat_t     annexb_expected[$];
  annexb_beat_t     burst[$];
  logic [POS_W-1:0] pkt_pos     = '0;
  logic             frag_pkt    = 1'b0;
  logic [2:0]       fu_f_nri    = 3'd0;
  int               mismatches  = 0;
  int               outstanding = 0;

  assign fail_count    = mismatches;
  assign pending_count = outstanding;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_beat(input logic [7:0] data, input logic nal_begin);
    burst.push_back('{data: data, nal_begin: nal_begin, run_end: 1'b0});
  endtask

  task automatic push_start_code();
    push_beat(8'h00, 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h01, 1'b0);
  endtask

  task automatic predict_annexb(input logic [7:0] b, input logic last);
    annexb_beat_t tail;
    burst.delete();
    if (pkt_pos == POS_PAYLOAD_HDR) begin
      if (b[4:0] == FUA_TYPE) begin
        frag_pkt = 1'b1;
        fu_f_nri = b[7:5];
      end else begin
        frag_pkt = 1'b0;
        push_start_code();
        push_beat(b, 1'b0);
      end
    end else if (pkt_pos == POS_FU_HDR) begin
      if (!frag_pkt) begin
        push_beat(b, 1'b0);
      end else if (b[7] && !b[6]) begin
        // A fragment flagged as both start and end is treated as an end.
        push_start_code();
        push_beat({fu_f_nri, 5'd0} | (b & TYPE_MASK), 1'b0);
      end
    end else if (pkt_pos >= POS_PAYLOAD) begin
      push_beat(b, 1'b0);
    end
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.run_end = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) annexb_expected.push_back(burst[i]);
    if (last) begin
      pkt_pos  = '0;
      frag_pkt = 1'b0;
    end else if (pkt_pos < POS_MAX) begin
      pkt_pos = pkt_pos + 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    annexb_beat_t want;
    if (!rst_n) begin
      pkt_pos  = '0;
      frag_pkt = 1'b0;
      fu_f_nri = 3'd0;
      annexb_expected.delete();
    end else begin
      if (in_valid && !in_stall) predict_annexb(in_pkt_byte, in_last_of_packet);
      if (out_valid && !out_stall) begin
        if (annexb_expected.size() == 0) begin
          report_mismatch($sformatf("beat %02h with nothing expected", out_byte));
        end else begin
          want = annexb_expected.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          if (out_nal_begin !== want.nal_begin)
            report_mismatch($sformatf("out_nal_begin %b, expected %b",
                                      out_nal_begin, want.nal_begin));
          if (out_last_of_run !== want.run_end)
            report_mismatch($sformatf("out_last_of_run %b, expected %b",
                                      out_last_of_run, want.run_end));
        end
      end
    end
    outstanding <= annexb_expected.size();
  end

endmodule

[verif/tb_rtp_h264_depacketizer.sv]
// ----------------------------------------------------------------------------
// tb_rtp_h264_depacketizer
// Drives RTP packets into the depacketizer: a few hand-built packets first,
// then random single NAL, FU-A, short and noise packets with one overlong
// packet, under random gaps and receiver stalls. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rtp_h264_depacketizer;
  import rtpd_pkg::*;

  typedef enum {
    PK_SINGLE,
    PK_FU_START,
    PK_FU_MID,
    PK_FU_END,
    PK_FU_BOTH,
    PK_SHORT,
    PK_NOISE
  } pkt_kind_t;

  localparam int RANDOM_ITEMS     = 150;
  localparam int OVERLONG_PAYLOAD = MAX_PACKET_BYTES + 16;
  localparam int LIMIT_CYCLES     = 3_000_000;
  localparam int DRAIN_CYCLES     = 200_000;
  localparam int TAIL_CYCLES      = 20;

  logic       clk;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic [7:0] in_pkt_byte       = 8'h00;
  logic       in_last_of_packet = 1'b0;
  logic       out_stall         = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_nal_begin;
  logic       out_last_of_run;
  int         fail_count;
  int         pending_count;
  bit         calm = 1'b0;
  logic [7:0] pkt[$];

  rtp_h264_depacketizer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pkt_byte       (in_pkt_byte),
    .in_last_of_packet (in_last_of_packet),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_nal_begin     (out_nal_begin),
    .out_last_of_run   (out_last_of_run)
  );

  rtpd_annexb_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pkt_byte       (in_pkt_byte),
    .in_last_of_packet (in_last_of_packet),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_nal_begin     (out_nal_begin),
    .out_last_of_run   (out_last_of_run),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pkt_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return PK_SINGLE;
    if (r < 35) return PK_FU_START;
    if (r < 48) return PK_FU_MID;
    if (r < 60) return PK_FU_END;
    if (r < 70) return PK_FU_BOTH;
    if (r < 85) return PK_SHORT;
    return PK_NOISE;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    in_valid          <= 1'b1;
    in_pkt_byte       <= b;
    in_last_of_packet <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_header();
    for (int i = 0; i < 12; i++) send_beat(i[0] ? 8'hff : 8'h00, 1'b0);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic build_packet(input pkt_kind_t kind, input int payload_len);
    logic [7:0] b;
    int         total;
    pkt.delete();
    case (kind)
      PK_SHORT: begin
        total = $urandom_range(1, 14);
        repeat (total) pkt.push_back(8'($urandom));
      end
      PK_NOISE: begin
        repeat (payload_len + 13) pkt.push_back(8'($urandom));
      end
      default: begin
        repeat (12) pkt.push_back(8'($urandom));
        if (kind == PK_SINGLE) begin
          b = 8'($urandom);
          while (b[4:0] == FUA_TYPE) b = 8'($urandom);
          pkt.push_back(b);
        end else begin
          pkt.push_back({3'($urandom), FUA_TYPE});
          b    = 8'($urandom);
          b[7] = (kind == PK_FU_START) || (kind == PK_FU_BOTH);
          b[6] = (kind == PK_FU_END) || (kind == PK_FU_BOTH);
          pkt.push_back(b);
        end
        repeat (payload_len) pkt.push_back(8'($urandom));
      end
    endcase
  endtask

  initial begin
    int n;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(8 * LIMIT_CYCLES);
    $display("FAIL rtp_h264_depacketizer");
    $finish;
  end

  initial begin
    int random_items;
    int pkt_count;
    int payload_len;
    int drain_count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Packet shorter than the RTP header.
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b1);
    // Single NAL unit ending on its header byte.
    send_header();
    send_beat(8'hff, 1'b1);
    // FU-A with start and end both set.
    send_header();
    send_beat(8'h1c, 1'b0);
    send_beat(8'hc0, 1'b0);
    send_beat(8'hff, 1'b1);
    // FU-A start ending on the FU header.
    send_header();
    send_beat(8'hfc, 1'b0);
    send_beat(8'h9f, 1'b1);
    // Single NAL unit with payload.
    send_header();
    send_beat(8'h00, 1'b0);
    send_beat(8'h5a, 1'b0);
    send_beat(8'ha5, 1'b1);
    // FU-A end fragment.
    send_header();
    send_beat(8'h7c, 1'b0);
    send_beat(8'h45, 1'b0);
    send_beat(8'h00, 1'b1);
    drain_results();

    random_items = 0;
    pkt_count    = 0;
    while (random_items < RANDOM_ITEMS) begin
      calm        = ($urandom_range(0, 4) == 0);
      payload_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 20);
      build_packet(pick_kind(), payload_len);
      random_items += pkt.size();
      send_packet();
      pkt_count++;
      if (pkt_count == 4) begin
        // The byte position saturates well before the end of this packet.
        calm = 1'b1;
        build_packet(PK_SINGLE, OVERLONG_PAYLOAD);
        send_packet();
      end
      if (pkt_count == 2 || $urandom_range(0, 9) == 0) drain_results();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    drain_count = 0;
    while (pending_count != 0 && drain_count < DRAIN_CYCLES) begin
      @(posedge clk);
      drain_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS rtp_h264_depacketizer");
    end else begin
      $display("FAIL rtp_h264_depacketizer");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rtpd_pkg.sv
hdl/rtpd_front.sv
hdl/rtpd_queue.sv
hdl/rtpd_back.sv
hdl/rtp_h264_depacketizer.sv
hdl/rtpd_checker.sv
verif/rtpd_annexb_checker.sv
verif/tb_rtp_h264_depacketizer.sv
